// ----- hdl/mecanum_drive_duty_mixer_unit_defines.svh -----
// Assertion helpers used by the mixer control RTL (mdm_ctrl).
// Both expect clk and arst_n in the scope where they are used.
`ifndef MECANUM_DRIVE_DUTY_MIXER_UNIT_DEFINES_SVH
`define MECANUM_DRIVE_DUTY_MIXER_UNIT_DEFINES_SVH

// same-cycle implication
`define MDM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MDM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/mdm_pkg.sv -----
package mdm_pkg;

	// fixed-point gains, 16 fraction bits
	localparam int K_PLANAR   = 46323;
	localparam int K_ROT      = 25611;
	localparam int K_DUTY     = 109316;
	localparam int DUTY_MID   = 5000;
	localparam int DUTY_LIMIT = 4800;

	// shared divider operand widths
	localparam int NUM_W = 64;
	localparam int DEN_W = 50;
	localparam int OFF_W = 50;

	localparam logic [1:0] REG_RATE_LIMIT = 2'd0;
	localparam logic [1:0] REG_ACCEL_STEP = 2'd1;
	localparam logic [1:0] REG_SLIP_MARGIN = 2'd2;
	localparam logic [1:0] REG_SIGN_MASK  = 2'd3;

	localparam logic [1:0] IDX_LAST = 2'd3;

	typedef struct packed {
		logic        rate_limit_enable;
		logic [9:0]  accel_step;
		logic [11:0] slip_margin;
		logic [3:0]  wheel_sign_mask;
	} cfg_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_SQX,
		OP_S2,
		OP_SLIP,
		OP_SQRT_GO,
		OP_NUM,
		OP_DIV_GO,
		OP_DIV_STORE,
		OP_SUMS,
		OP_PSUM,
		OP_PDIF,
		OP_TGT,
		OP_DIFF,
		OP_MAXD,
		OP_HOLD,
		OP_OFF,
		OP_MAXO,
		OP_UNSC
	} dp_op_t;

	// which quantity the shared divider is working on
	typedef enum logic [1:0] {
		PH_X,
		PH_Y,
		PH_RL,
		PH_SC
	} phase_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] idx;
		phase_t     phase;
		logic       take;
		logic       load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic slip;
		logic sqrt_done;
		logic div_done;
		logic rl_on;
		logic scaled;
	} dp_sts_t;

endpackage

// ----- hdl/mdm_sqrt.sv -----
module mdm_sqrt import mdm_pkg::*; #(
	parameter int RAD_W = 44
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [RAD_W-1:0]   rad,
	output logic [RAD_W/2-1:0] root,
	output logic               done
);

	localparam int ROOT_W = RAD_W / 2;
	localparam int CNT_W  = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [ROOT_W+1:0] rem_sh;
	logic [ROOT_W+1:0] trial;
	logic              ge;

	// two radicand bits per step, one root bit out
	always_comb begin
		rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial  = {root_q, 2'b01};
		ge     = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder stays below 2^ROOT_W until the last step, whose remainder is unused
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= ROOT_W'(ge ? rem_sh - trial : rem_sh);
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

// ----- hdl/mdm_div.sv -----
module mdm_div import mdm_pkg::*; #(
	parameter int QUO_W = 23
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo,
	output logic             done
);

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] lo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0] trial;
	logic           ge;

	// restoring division; caller guarantees num < den * 2^QUO_W
	always_comb begin
		trial = {rem_q, lo_q[QUO_W-1]};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(num >> QUO_W);
			lo_q  <= num[QUO_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= DEN_W'(ge ? trial - {1'b0, den_q} : trial);
			lo_q  <= {lo_q[QUO_W-2:0], ge};
		end
	end

	assign quo  = lo_q;
	assign done = done_q;

endmodule

// ----- hdl/mdm_dp.sv -----
module mdm_dp import mdm_pkg::*; #(
	parameter int FRAC = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  dp_cmd_t            cmd,
	output dp_sts_t            sts,
	input  logic signed [13:0] vel_x,
	input  logic signed [13:0] vel_y,
	input  logic signed [15:0] vel_rot,
	input  logic [13:0]        ground_speed,
	output logic [13:0]        duty_front_left,
	output logic [13:0]        duty_front_right,
	output logic [13:0]        duty_back_left,
	output logic [13:0]        duty_back_right,
	output logic               slip_limited,
	output logic               duty_scaled
);

	localparam int XQ_W  = FRAC + 16;
	localparam int SUM_W = FRAC + 17;
	localparam int PR_W  = FRAC + 34;
	localparam int TS_W  = FRAC + 36;
	localparam int TG_W  = FRAC + 18;
	localparam int DF_W  = FRAC + 19;
	localparam int MD_W  = FRAC + 18;
	localparam int CW    = (FRAC + 19 > 33) ? FRAC + 19 : 33;
	localparam int SQ_W  = 28 + 2 * FRAC;
	localparam int RT_W  = SQ_W / 2;
	localparam int QW    = FRAC + 15;

	// captured item
	logic signed [13:0] x_q, y_q;
	logic signed [15:0] rot_q;
	logic [13:0]        gs_q;

	logic [14:0]               lim_q;
	logic [26:0]               sqx_q;
	logic [27:0]               s2_q;
	logic                      slip_q;
	logic signed [XQ_W-1:0]    xq_q, yq_q;
	logic signed [SUM_W-1:0]   sum_q, dif_q;
	logic signed [31:0]        rq_q;
	logic signed [PR_W-1:0]    psum_q, pdif_q;
	logic signed [TG_W-1:0]    tgt_q  [4];
	logic signed [31:0]        prev_q [4];
	logic signed [DF_W-1:0]    diff_q [4];
	logic [MD_W-1:0]           maxd_q;
	logic [NUM_W-1:0]          num_q;
	logic [DEN_W-1:0]          den_q;
	logic                      neg_q;
	logic signed [OFF_W-1:0]   off_q  [4];
	logic [OFF_W-1:0]          maxo_q;
	logic                      scaled_q;
	logic [13:0]               duty_q [4];
	logic [13:0]               out_duty_q [4];
	logic                      out_slip_q, out_scaled_q;

	// units
	logic [RT_W-1:0]  root;
	logic             sqrt_done;
	logic [QW-1:0]    quo;
	logic             div_done;
	logic [NUM_W-1:0] div_num;

	mdm_sqrt #(.RAD_W(SQ_W)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == OP_SQRT_GO),
		.rad    (SQ_W'(s2_q) << (2 * FRAC)),
		.root   (root),
		.done   (sqrt_done)
	);

	// rounding half away from zero: add half the divisor up front
	assign div_num = num_q + NUM_W'(den_q >> 1);

	mdm_div #(.QUO_W(QW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == OP_DIV_GO),
		.num    (div_num),
		.den    (den_q),
		.quo    (quo),
		.done   (div_done)
	);

	// magnitudes, their maxima and the rate-limit check
	logic [13:0]        mag_x, mag_y;
	logic [MD_W-1:0]    mag_d [4];
	logic [OFF_W-1:0]   mag_o [4];
	logic [MD_W-1:0]    maxd_01, maxd_23, maxd_all;
	logic [OFF_W-1:0]   maxo_01, maxo_23, maxo_all;
	logic [MD_W-1:0]    stepq;
	logic               rl_on;

	always_comb begin
		mag_x = x_q[13] ? 14'(-x_q) : 14'(x_q);
		mag_y = y_q[13] ? 14'(-y_q) : 14'(y_q);
		for (int i = 0; i < 4; i++) begin
			mag_d[i] = diff_q[i][DF_W-1] ? MD_W'(-diff_q[i]) : MD_W'(diff_q[i]);
			mag_o[i] = off_q[i][OFF_W-1] ? OFF_W'(-off_q[i]) : OFF_W'(off_q[i]);
		end
		maxd_01  = (mag_d[0] > mag_d[1]) ? mag_d[0] : mag_d[1];
		maxd_23  = (mag_d[2] > mag_d[3]) ? mag_d[2] : mag_d[3];
		maxd_all = (maxd_01 > maxd_23) ? maxd_01 : maxd_23;
		maxo_01  = (mag_o[0] > mag_o[1]) ? mag_o[0] : mag_o[1];
		maxo_23  = (mag_o[2] > mag_o[3]) ? mag_o[2] : mag_o[3];
		maxo_all = (maxo_01 > maxo_23) ? maxo_01 : maxo_23;
		stepq    = MD_W'(cfg.accel_step) << FRAC;
		rl_on    = cfg.rate_limit_enable && (maxd_q != '0) && (maxd_q >= stepq);
	end

	// shared numerator multiplier
	logic [13:0]        mul_a;
	logic [OFF_W-1:0]   mul_b;
	logic [NUM_W-1:0]   prod;
	logic [NUM_W-1:0]   num_d;
	logic               neg_d;

	always_comb begin
		case (cmd.phase)
			PH_X: begin
				mul_a = mag_x;
				mul_b = OFF_W'(lim_q);
				neg_d = x_q[13];
			end
			PH_Y: begin
				mul_a = mag_y;
				mul_b = OFF_W'(lim_q);
				neg_d = y_q[13];
			end
			PH_RL: begin
				mul_a = 14'(cfg.accel_step);
				mul_b = OFF_W'(mag_d[cmd.idx]);
				neg_d = diff_q[cmd.idx][DF_W-1];
			end
			PH_SC: begin
				mul_a = 14'(DUTY_LIMIT);
				mul_b = mag_o[cmd.idx];
				neg_d = off_q[cmd.idx][OFF_W-1];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
				neg_d = 1'b0;
			end
		endcase
		prod = NUM_W'(mul_a) * NUM_W'(mul_b);
		case (cmd.phase)
			PH_X, PH_Y: num_d = prod << (2 * FRAC);
			PH_RL:      num_d = prod << FRAC;
			default:    num_d = prod;
		endcase
	end

	// target wheel speeds: (planar +/- rotation) / 2^16, rounded
	logic signed [TS_W-1:0] rqs, ps, pd;
	logic signed [TS_W-1:0] tsum [4];
	logic [TS_W-1:0]        tmag;
	logic [TS_W-1:0]        trnd;
	logic signed [TG_W-1:0] tgt_d [4];

	always_comb begin
		rqs = TS_W'(rq_q) <<< FRAC;
		ps  = TS_W'(psum_q);
		pd  = TS_W'(pdif_q);
		tsum[0] = ps - rqs;
		tsum[1] = pd + rqs;
		tsum[2] = pd - rqs;
		tsum[3] = ps + rqs;
		tmag = '0;
		trnd = '0;
		for (int i = 0; i < 4; i++) begin
			tmag     = tsum[i][TS_W-1] ? TS_W'(-tsum[i]) : TS_W'(tsum[i]);
			trnd     = (tmag + (TS_W'(1) << 15)) >> 16;
			tgt_d[i] = tsum[i][TS_W-1] ? TG_W'(-trnd) : TG_W'(trnd);
		end
	end

	// duty offsets, the unscaled duty path and the scaled duty value
	logic signed [OFF_W-1:0] vprod;
	logic signed [OFF_W-1:0] off_d;
	logic [OFF_W-1:0]        urnd;
	logic [13:0]             unsc_d [4];
	logic [15:0]             sc_o;
	logic [13:0]             sc_d;

	always_comb begin
		vprod = OFF_W'(prev_q[cmd.idx]) * OFF_W'(K_DUTY);
		off_d = cfg.wheel_sign_mask[cmd.idx] ? -vprod : vprod;
		urnd  = '0;
		for (int i = 0; i < 4; i++) begin
			urnd = (mag_o[i] + (OFF_W'(1) << (FRAC + 15))) >> (FRAC + 16);
			unsc_d[i] = off_q[i][OFF_W-1] ? 14'(16'(DUTY_MID) - 16'(urnd))
			                              : 14'(16'(DUTY_MID) + 16'(urnd));
		end
		sc_o = 16'(quo);
		sc_d = neg_q ? 14'(16'(DUTY_MID) - sc_o) : 14'(16'(DUTY_MID) + sc_o);
	end

	// stored wheel speeds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				prev_q[i] <= '0;
			end
		end else begin
			case (cmd.op)
				OP_HOLD: begin
					for (int i = 0; i < 4; i++) begin
						prev_q[i] <= 32'(tgt_q[i]);
					end
				end
				OP_DIV_STORE: begin
					if (cmd.phase == PH_RL) begin
						prev_q[cmd.idx] <= prev_q[cmd.idx] + (neg_q ? -32'(quo) : 32'(quo));
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			x_q   <= vel_x;
			y_q   <= vel_y;
			rot_q <= vel_rot;
			gs_q  <= ground_speed;
		end
		case (cmd.op)
			OP_SQX: begin
				sqx_q <= 27'(x_q * x_q);
				lim_q <= 15'(gs_q) + 15'(cfg.slip_margin);
			end
			OP_S2: s2_q <= 28'(sqx_q) + 28'(y_q * y_q);
			OP_SLIP: begin
				slip_q <= 30'(s2_q) > 30'(lim_q) * 30'(lim_q);
				xq_q   <= XQ_W'(x_q) <<< FRAC;
				yq_q   <= XQ_W'(y_q) <<< FRAC;
			end
			OP_NUM: begin
				num_q <= num_d;
				neg_q <= neg_d;
				case (cmd.phase)
					PH_X, PH_Y: den_q <= DEN_W'(root);
					PH_RL:      den_q <= DEN_W'(maxd_q);
					default:    den_q <= maxo_q;
				endcase
			end
			OP_DIV_STORE: begin
				case (cmd.phase)
					PH_X:  xq_q <= neg_q ? -XQ_W'(quo) : XQ_W'(quo);
					PH_Y:  yq_q <= neg_q ? -XQ_W'(quo) : XQ_W'(quo);
					PH_SC: duty_q[cmd.idx] <= sc_d;
					default: ;
				endcase
			end
			OP_SUMS: begin
				sum_q <= SUM_W'(xq_q) + SUM_W'(yq_q);
				dif_q <= SUM_W'(yq_q) - SUM_W'(xq_q);
				rq_q  <= rot_q * K_ROT;
			end
			OP_PSUM: psum_q <= PR_W'(sum_q) * PR_W'(K_PLANAR);
			OP_PDIF: pdif_q <= PR_W'(dif_q) * PR_W'(K_PLANAR);
			OP_TGT: begin
				for (int i = 0; i < 4; i++) begin
					tgt_q[i] <= tgt_d[i];
				end
			end
			OP_DIFF: begin
				for (int i = 0; i < 4; i++) begin
					diff_q[i] <= DF_W'(CW'(tgt_q[i]) - CW'(prev_q[i]));
				end
			end
			OP_MAXD: maxd_q <= maxd_all;
			OP_OFF: off_q[cmd.idx] <= off_d;
			OP_MAXO: begin
				maxo_q   <= maxo_all;
				scaled_q <= maxo_all >= (OFF_W'(DUTY_LIMIT) << (FRAC + 16));
			end
			OP_UNSC: begin
				for (int i = 0; i < 4; i++) begin
					duty_q[i] <= unsc_d[i];
				end
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			for (int i = 0; i < 4; i++) begin
				out_duty_q[i] <= duty_q[i];
			end
			out_slip_q   <= slip_q;
			out_scaled_q <= scaled_q;
		end
	end

	always_comb begin
		sts.slip      = slip_q;
		sts.sqrt_done = sqrt_done;
		sts.div_done  = div_done;
		sts.rl_on     = rl_on;
		sts.scaled    = scaled_q;
	end

	assign duty_front_left  = out_duty_q[0];
	assign duty_front_right = out_duty_q[1];
	assign duty_back_left   = out_duty_q[2];
	assign duty_back_right  = out_duty_q[3];
	assign slip_limited     = out_slip_q;
	assign duty_scaled      = out_scaled_q;

endmodule

// ----- hdl/mdm_ctrl.sv -----
`include "mecanum_drive_duty_mixer_unit_defines.svh"

module mdm_ctrl import mdm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_SQX,
		S_S2,
		S_SLIP,
		S_CHK,
		S_SQGO,
		S_SQWAIT,
		S_NUM,
		S_DGO,
		S_DWAIT,
		S_DST,
		S_SUMS,
		S_PSUM,
		S_PDIF,
		S_TGT,
		S_DIFF,
		S_MAXD,
		S_RLCHK,
		S_HOLD,
		S_OFF,
		S_MAXO,
		S_SCCHK,
		S_UNSC,
		S_OUT
	} state_t;

	state_t     state_q;
	logic [1:0] idx_q;
	phase_t     phase_q;
	logic       in_stall_q;
	logic       out_valid_q;

	always_comb begin
		case (state_q)
			S_SQX:  cmd.op = OP_SQX;
			S_S2:   cmd.op = OP_S2;
			S_SLIP: cmd.op = OP_SLIP;
			S_SQGO: cmd.op = OP_SQRT_GO;
			S_NUM:  cmd.op = OP_NUM;
			S_DGO:  cmd.op = OP_DIV_GO;
			S_DST:  cmd.op = OP_DIV_STORE;
			S_SUMS: cmd.op = OP_SUMS;
			S_PSUM: cmd.op = OP_PSUM;
			S_PDIF: cmd.op = OP_PDIF;
			S_TGT:  cmd.op = OP_TGT;
			S_DIFF: cmd.op = OP_DIFF;
			S_MAXD: cmd.op = OP_MAXD;
			S_HOLD: cmd.op = OP_HOLD;
			S_OFF:  cmd.op = OP_OFF;
			S_MAXO: cmd.op = OP_MAXO;
			S_UNSC: cmd.op = OP_UNSC;
			default: cmd.op = OP_NONE;
		endcase
		cmd.idx      = idx_q;
		cmd.phase    = phase_q;
		cmd.take     = in_valid & ~in_stall_q;
		cmd.load_out = (state_q == S_OUT) & (~out_valid_q | ~out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			phase_q     <= PH_X;
			in_stall_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !cmd.load_out) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.take) begin
						in_stall_q <= 1'b1;
						state_q    <= S_SQX;
					end
				end
				S_SQX:  state_q <= S_S2;
				S_S2:   state_q <= S_SLIP;
				S_SLIP: state_q <= S_CHK;
				S_CHK:  state_q <= sts.slip ? S_SQGO : S_SUMS;
				S_SQGO: state_q <= S_SQWAIT;
				S_SQWAIT: begin
					if (sts.sqrt_done) begin
						phase_q <= PH_X;
						idx_q   <= '0;
						state_q <= S_NUM;
					end
				end
				S_NUM: state_q <= S_DGO;
				S_DGO: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (sts.div_done) begin
						state_q <= S_DST;
					end
				end
				S_DST: begin
					case (phase_q)
						PH_X: begin
							phase_q <= PH_Y;
							state_q <= S_NUM;
						end
						PH_Y: state_q <= S_SUMS;
						PH_RL: begin
							if (idx_q == IDX_LAST) begin
								idx_q   <= '0;
								state_q <= S_OFF;
							end else begin
								idx_q   <= idx_q + 1'b1;
								state_q <= S_NUM;
							end
						end
						PH_SC: begin
							if (idx_q == IDX_LAST) begin
								state_q <= S_OUT;
							end else begin
								idx_q   <= idx_q + 1'b1;
								state_q <= S_NUM;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_SUMS: state_q <= S_PSUM;
				S_PSUM: state_q <= S_PDIF;
				S_PDIF: state_q <= S_TGT;
				S_TGT:  state_q <= S_DIFF;
				S_DIFF: state_q <= S_MAXD;
				S_MAXD: state_q <= S_RLCHK;
				S_RLCHK: begin
					idx_q <= '0;
					if (sts.rl_on) begin
						phase_q <= PH_RL;
						state_q <= S_NUM;
					end else begin
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					idx_q   <= '0;
					state_q <= S_OFF;
				end
				S_OFF: begin
					if (idx_q == IDX_LAST) begin
						idx_q   <= '0;
						state_q <= S_MAXO;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_MAXO: state_q <= S_SCCHK;
				S_SCCHK: begin
					idx_q <= '0;
					if (sts.scaled) begin
						phase_q <= PH_SC;
						state_q <= S_NUM;
					end else begin
						state_q <= S_UNSC;
					end
				end
				S_UNSC: state_q <= S_OUT;
				S_OUT: begin
					if (cmd.load_out) begin
						out_valid_q <= 1'b1;
						in_stall_q  <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = in_stall_q;
	assign out_valid = out_valid_q;

	`MDM_ASSERT_NEXT(a_take_starts, cmd.take, in_stall_q && state_q == S_SQX, "item accept did not start work")
	`MDM_ASSERT_NOW(a_ready_only_idle, !in_stall_q, state_q == S_IDLE, "ready outside idle")
	`MDM_ASSERT_NEXT(a_result_waits, state_q == S_OUT && out_valid_q && out_stall, state_q == S_OUT && out_valid_q, "waiting result lost")

endmodule

// ----- hdl/mecanum_drive_duty_mixer_unit.sv -----
// channel | handshake            | payload
// in      | in_valid / in_stall  | vel_x, vel_y, vel_rot, ground_speed
// out     | out_valid / out_stall| duty_front_left .. duty_back_right, slip_limited, duty_scaled
// cfg     | cfg_write            | cfg_index, cfg_data
//
// One item at a time. The mix and duty path adds a square root when the slip cut
// applies, and divides on the shared restoring divider: two for the slip cut,
// four for the rate limit, four for duty scaling.
// Reset clears control and the stored wheel speeds; the config takes its defaults.
// The next item is taken while a finished result waits behind out_stall.
module mecanum_drive_duty_mixer_unit import mdm_pkg::*; #(
	parameter int SPEED_FRAC_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [13:0] vel_x,
	input  logic signed [13:0] vel_y,
	input  logic signed [15:0] vel_rot,
	input  logic [13:0]        ground_speed,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [13:0]        duty_front_left,
	output logic [13:0]        duty_front_right,
	output logic [13:0]        duty_back_left,
	output logic [13:0]        duty_back_right,
	output logic               slip_limited,
	output logic               duty_scaled,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [11:0]        cfg_data
);

	cfg_t    cfg_q;
	dp_cmd_t cmd;
	dp_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_limit_enable <= 1'b0;
			cfg_q.accel_step        <= 10'd6;
			cfg_q.slip_margin       <= 12'd500;
			cfg_q.wheel_sign_mask   <= 4'd5;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_RATE_LIMIT:  cfg_q.rate_limit_enable <= cfg_data[0];
				REG_ACCEL_STEP:  cfg_q.accel_step        <= cfg_data[9:0];
				REG_SLIP_MARGIN: cfg_q.slip_margin       <= cfg_data;
				REG_SIGN_MASK:   cfg_q.wheel_sign_mask   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	mdm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	mdm_dp #(.FRAC(SPEED_FRAC_BITS)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.cmd              (cmd),
		.sts              (sts),
		.vel_x            (vel_x),
		.vel_y            (vel_y),
		.vel_rot          (vel_rot),
		.ground_speed     (ground_speed),
		.duty_front_left  (duty_front_left),
		.duty_front_right (duty_front_right),
		.duty_back_left   (duty_back_left),
		.duty_back_right  (duty_back_right),
		.slip_limited     (slip_limited),
		.duty_scaled      (duty_scaled)
	);

endmodule

// ----- dv/mecanum_drive_duty_mixer_unit_chk.sv -----
module mecanum_drive_duty_mixer_unit_chk import mdm_pkg::*; #(
	parameter int SPEED_FRAC_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [13:0] vel_x,
	input  logic signed [13:0] vel_y,
	input  logic signed [15:0] vel_rot,
	input  logic [13:0]        ground_speed,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [13:0]        duty_front_left,
	input  logic [13:0]        duty_front_right,
	input  logic [13:0]        duty_back_left,
	input  logic [13:0]        duty_back_right,
	input  logic               slip_limited,
	input  logic               duty_scaled,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [11:0]        cfg_data,
	output int                 fail_count,
	output int                 pending
);

	typedef struct {
		logic [13:0] fl, fr, bl, br;
		logic        slip, scaled;
	} duty_set_t;

	duty_set_t   duty_q[$];
	cfg_t        cfg;
	longint      wheel_speed[4];

	// round to nearest, halves away from zero; den > 0
	function automatic longint round_div(longint num, longint den);
		longint q;
		q = ((num < 0 ? -num : num) + den / 2) / den;
		return num < 0 ? -q : q;
	endfunction

	function automatic longint floor_sqrt(longint v);
		longint r, b;
		r = 0;
		b = 64'sd1 <<< 62;
		while (b > v) b = b >>> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	// updates wheel_speed, returns the expected duties
	function automatic duty_set_t mix_duties(longint x, longint y, longint rot, longint gs);
		longint    one, lim, s2, xq, yq, rq, r, maxd, maxo, d, stepq, cur, v, o;
		longint    tgt[4], off[4];
		logic      slip, scaled;
		duty_set_t res;
		one = 64'sd1 <<< SPEED_FRAC_BITS;
		lim = gs + longint'(cfg.slip_margin);
		s2 = x * x + y * y;
		slip = s2 > lim * lim;
		xq = x * one;
		yq = y * one;
		if (slip) begin
			r = floor_sqrt(s2 <<< (2 * SPEED_FRAC_BITS));
			xq = round_div(x * lim * one * one, r);
			yq = round_div(y * lim * one * one, r);
		end
		rq = rot * one * K_ROT;
		tgt[0] = round_div(K_PLANAR * (xq + yq) - rq, 65536);
		tgt[1] = round_div(K_PLANAR * (yq - xq) + rq, 65536);
		tgt[2] = round_div(K_PLANAR * (yq - xq) - rq, 65536);
		tgt[3] = round_div(K_PLANAR * (xq + yq) + rq, 65536);
		maxd = 0;
		for (int i = 0; i < 4; i++) begin
			d = tgt[i] - wheel_speed[i];
			if (d < 0) d = -d;
			if (d > maxd) maxd = d;
		end
		stepq = longint'(cfg.accel_step) * one;
		for (int i = 0; i < 4; i++) begin
			cur = wheel_speed[i];
			if (cfg.rate_limit_enable && maxd != 0 && maxd >= stepq)
				cur = cur + round_div(stepq * (tgt[i] - cur), maxd);
			else
				cur = tgt[i];
			wheel_speed[i] = longint'(int'(cur));
		end
		maxo = 0;
		for (int i = 0; i < 4; i++) begin
			v = wheel_speed[i] * K_DUTY;
			off[i] = cfg.wheel_sign_mask[i] ? -v : v;
			if ((off[i] < 0 ? -off[i] : off[i]) > maxo) maxo = off[i] < 0 ? -off[i] : off[i];
		end
		scaled = maxo >= (longint'(DUTY_LIMIT) <<< (SPEED_FRAC_BITS + 16));
		for (int i = 0; i < 4; i++) begin
			if (scaled)
				o = round_div(DUTY_LIMIT * off[i], maxo);
			else
				o = round_div(off[i], 64'sd1 <<< (SPEED_FRAC_BITS + 16));
			tgt[i] = DUTY_MID + o;
		end
		res.fl = 14'(tgt[0]);
		res.fr = 14'(tgt[1]);
		res.bl = 14'(tgt[2]);
		res.br = 14'(tgt[3]);
		res.slip = slip;
		res.scaled = scaled;
		return res;
	endfunction

	function automatic void check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s expected %0d got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		duty_set_t e;
		if (!arst_n) begin
			duty_q.delete();
			cfg.rate_limit_enable = 1'b0;
			cfg.accel_step = 10'd6;
			cfg.slip_margin = 12'd500;
			cfg.wheel_sign_mask = 4'd5;
			for (int i = 0; i < 4; i++) wheel_speed[i] = 0;
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_RATE_LIMIT: cfg.rate_limit_enable = cfg_data[0];
					REG_ACCEL_STEP: cfg.accel_step = cfg_data[9:0];
					REG_SLIP_MARGIN: cfg.slip_margin = cfg_data[11:0];
					REG_SIGN_MASK: cfg.wheel_sign_mask = cfg_data[3:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (duty_q.size() == 0) begin
					$error("result item with no expectation waiting");
					fail_count++;
				end else begin
					e = duty_q.pop_front();
					check_field("duty_front_left", e.fl, duty_front_left);
					check_field("duty_front_right", e.fr, duty_front_right);
					check_field("duty_back_left", e.bl, duty_back_left);
					check_field("duty_back_right", e.br, duty_back_right);
					check_field("slip_limited", e.slip, slip_limited);
					check_field("duty_scaled", e.scaled, duty_scaled);
				end
			end
			if (in_valid && !in_stall)
				duty_q.push_back(mix_duties(vel_x, vel_y, vel_rot, ground_speed));
			pending = duty_q.size();
		end
	end

endmodule

// ----- dv/mecanum_drive_duty_mixer_unit_tb.sv -----
module mecanum_drive_duty_mixer_unit_tb import mdm_pkg::*;;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [13:0] vel_x = '0;
	logic signed [13:0] vel_y = '0;
	logic signed [15:0] vel_rot = '0;
	logic [13:0]        ground_speed = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [13:0]        duty_front_left, duty_front_right, duty_back_left, duty_back_right;
	logic               slip_limited, duty_scaled;
	logic               cfg_write = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [11:0]        cfg_data = '0;
	int                 fail_count, pending;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_token = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	mecanum_drive_duty_mixer_unit u_top (.*);

	mecanum_drive_duty_mixer_unit_chk u_chk (.*);

	// receiver: random stall, plus a long hold-off on request
	always @(posedge clk) begin
		static int hold_seen = 0;
		static int hold_left = 0;
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = 1500;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	initial begin
		#20000000;
		$display("mecanum_drive_duty_mixer_unit_tb: FAIL");
		$finish;
	end

	task automatic send_cmd(int x, int y, int rot, int gs);
		@(posedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		vel_x <= 14'(x);
		vel_y <= 14'(y);
		vel_rot <= 16'(rot);
		ground_speed <= 14'(gs);
		@(posedge clk);
		while (in_stall) @(posedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 12'(val);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	function automatic int rand_vel(int span);
		int k;
		k = $urandom_range(99);
		if (k < 10) return $urandom_range(1) ? span : -span;
		if (k < 25) return $urandom_range(100) - 50;
		return $urandom_range(2 * span) - span;
	endfunction

	task automatic send_random();
		int x, y, rot, gs, k, mag;
		x = rand_vel(8000);
		y = rand_vel(8000);
		rot = ($urandom_range(99) < 30) ? $urandom_range(400) - 200 : rand_vel(20000);
		mag = (x < 0 ? -x : x) + (y < 0 ? -y : y);
		k = $urandom_range(99);
		if (k < 35) gs = $urandom_range(16000);
		else if (k < 70) gs = $urandom_range(mag > 16000 ? 16000 : mag);
		else gs = $urandom_range(300);
		send_cmd(x, y, rot, gs);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed, at reset config
		send_cmd(0, 0, 0, 0);
		send_cmd(8000, 8000, 20000, 16000);
		send_cmd(-8000, -8000, -20000, 16000);
		send_cmd(8000, -8000, 0, 0);
		send_cmd(-8000, 8000, 0, 0);
		send_cmd(300, 400, 0, 0);     // speed exactly at the slip limit
		send_cmd(300, 401, 0, 0);     // just over it
		send_cmd(10, -20, 5, 16000);  // measured above command
		send_cmd(0, 0, 20000, 0);
		send_cmd(0, 0, -20000, 16383);
		send_cmd(1, -1, 1, 1);
		send_cmd(0, 8000, 0, 0);
		send_cmd(-8000, 0, 0, 16000);
		drain();
		write_reg(REG_RATE_LIMIT, 1);
		write_reg(REG_ACCEL_STEP, 1);
		write_reg(REG_SLIP_MARGIN, 0);
		write_reg(REG_SIGN_MASK, 0);
		send_cmd(0, 0, 0, 0);         // limit on, command back to rest
		send_cmd(5000, 0, 0, 16000);
		send_cmd(5000, 0, 0, 16000);
		send_cmd(-8000, 8000, 20000, 0);
		send_cmd(100, 100, 0, 16000);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_RATE_LIMIT, ph % 2);
			write_reg(REG_ACCEL_STEP, ph == 1 ? 1 : ph == 3 ? 1000 : $urandom_range(1, 1000));
			write_reg(REG_SLIP_MARGIN, ph == 2 ? 0 : ph == 4 ? 4000 : $urandom_range(4000));
			write_reg(REG_SIGN_MASK, ph == 5 ? 15 : ph == 6 ? 0 : $urandom_range(15));
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 85; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 85; end
				default: begin send_idle_pct = 12; recv_stall_pct = 12; end
			endcase
			if (ph == 0) hold_token++;
			repeat (240) send_random();
			drain();
		end

		if (fail_count == 0)
			$display("mecanum_drive_duty_mixer_unit_tb: PASS");
		else
			$display("mecanum_drive_duty_mixer_unit_tb: FAIL");
		$finish;
	end

endmodule
